// ----- design/pcfl_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfl_pkg: shared types and constants of the per-client flood limiter
// Request payloads, register indexes, controller states and the
// control and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pcfl_pkg;

    localparam int CLIENT_SLOTS_DEFAULT = 64;

    localparam int SLOT_W       = 6;
    localparam int TIME_W       = 32;
    localparam int DEMERIT_W    = 24;
    localparam int INTERVAL_W   = 16;
    localparam int SECONDS_W    = 15;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [DEMERIT_W-1:0]  DEMERIT_MAX        = '1;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 16'd2000;
    localparam logic [DEMERIT_W-1:0]  DEMERIT_LIMIT_RESET = 24'd5000;

    localparam int MS_PER_SEC   = 1000;
    localparam int ROUND_UP_MS  = 999;
    localparam int RECIP_SHIFT  = 25;
    localparam int RECIP_W      = 16;
    localparam int RECIP_1000   = (1 << RECIP_SHIFT) / MS_PER_SEC;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEMERIT_LIMIT = 1'd1;

    typedef struct packed {
        logic [SLOT_W-1:0] client_slot;
        logic [TIME_W-1:0] now_ms;
        logic              bypass;
    } in_item_t;

    typedef struct packed {
        logic [DEMERIT_W-1:0] wait_ms;
        logic [SECONDS_W-1:0] wait_seconds;
        logic                 limited;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_EXCESS,
        ST_SCALE,
        ST_FIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic write_back;
        logic excess;
        logic scale;
        logic fix;
    } cmd_t;

    typedef struct packed {
        logic skip;
    } status_t;

endpackage

// ----- design/pcfl_ram.sv -----
// ----------------------------------------------------------------------------
// pcfl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pcfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcfl_ctrl: sequencing controller of the flood limiter
// Accepts one request at a time, steps the datapath through update, excess
// and seconds conversion unless exempt, and holds the result until taken.
// ----------------------------------------------------------------------------
module pcfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  pcfl_pkg::status_t status,
    output pcfl_pkg::cmd_t    cmd
);
    import pcfl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.skip ? ST_OUT : ST_CALC;
                end
            end
            ST_CALC:   state_next = ST_EXCESS;
            ST_EXCESS: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FIX;
            ST_FIX:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = accept;
                cmd.clear   = accept && status.skip;
            end
            ST_CALC:   cmd.write_back = 1'b1;
            ST_EXCESS: cmd.excess     = 1'b1;
            ST_SCALE:  cmd.scale      = 1'b1;
            ST_FIX:    cmd.fix        = 1'b1;
            ST_OUT:    out_valid      = 1'b1;
            default:   in_stall       = 1'b1;
        endcase
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while a result is pending");

    a_skip_is_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && status.skip) |=> out_valid)
        else $error("exempt request did not produce a result at once");

    a_update_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_back |-> ##4 out_valid)
        else $error("table update not followed by a result");

endmodule

// ----- design/pcfl_datapath.sv -----
// ----------------------------------------------------------------------------
// pcfl_datapath: client table, demerit arithmetic and result register
// Holds the configuration, the per-client time and demerit table, and
// computes the excess in milliseconds and rounded-up seconds.
// ----------------------------------------------------------------------------
module pcfl_datapath #(
    parameter int CLIENT_SLOTS = pcfl_pkg::CLIENT_SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcfl_pkg::in_item_t                  in_data,
    output pcfl_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [pcfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcfl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  pcfl_pkg::cmd_t                      cmd,
    output pcfl_pkg::status_t                   status
);
    import pcfl_pkg::*;

    localparam int ADDR_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int ENTRY_W = TIME_W + DEMERIT_W;
    localparam int X_W     = DEMERIT_W + 1;
    localparam int PROD_W  = X_W + RECIP_W;
    localparam logic [8:0] SLOT_LIMIT = 9'(CLIENT_SLOTS);

    logic [INTERVAL_W-1:0]   min_interval_reg;
    logic [DEMERIT_W-1:0]    demerit_limit_reg;
    logic [CLIENT_SLOTS-1:0] valid_reg;
    logic                    hit_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [DEMERIT_W-1:0]    dem_reg;
    logic [DEMERIT_W-1:0]    ms_reg;
    logic [SECONDS_W-1:0]    qest_reg;
    out_item_t               result_reg;

    logic [ADDR_W-1:0]       raddr;
    logic [ENTRY_W-1:0]      rdata;
    logic [TIME_W-1:0]       last_time;
    logic [DEMERIT_W-1:0]    dem_old;
    logic [TIME_W-1:0]       elapsed;
    logic [X_W-1:0]          grown;
    logic [X_W-1:0]          diff;
    logic [DEMERIT_W-1:0]    dem_next;
    logic [DEMERIT_W-1:0]    ms_next;
    logic [X_W-1:0]          x_val;
    logic [PROD_W-1:0]       prod;
    logic [X_W-1:0]          rem;
    logic [SECONDS_W-1:0]    q_next;

    assign raddr = ADDR_W'(in_data.client_slot);
    assign status.skip = (min_interval_reg == '0) || in_data.bypass
                         || ({3'b000, in_data.client_slot} >= SLOT_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg  <= MIN_INTERVAL_RESET;
            demerit_limit_reg <= DEMERIT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_INTERVAL:  min_interval_reg  <= cfg_data[INTERVAL_W-1:0];
                CFG_DEMERIT_LIMIT: demerit_limit_reg <= cfg_data[DEMERIT_W-1:0];
                default:           min_interval_reg  <= min_interval_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write_back)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    pcfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLIENT_SLOTS),
        .ADDR_W(ADDR_W)
    ) u_table (
        .clk  (clk),
        .we   (cmd.write_back),
        .waddr(addr_reg),
        .wdata({now_reg, dem_next}),
        .re   (cmd.capture),
        .raddr(raddr),
        .rdata(rdata)
    );

    // An entry never written since reset reads as zero time and zero demerits.
    assign last_time = hit_reg ? rdata[ENTRY_W-1:DEMERIT_W] : '0;
    assign dem_old   = hit_reg ? rdata[DEMERIT_W-1:0] : '0;
    assign elapsed   = now_reg - last_time;
    assign grown     = {1'b0, dem_old} + X_W'(min_interval_reg);
    assign diff      = grown - elapsed[X_W-1:0];

    always_comb
    begin
        if ({{(TIME_W - X_W){1'b0}}, grown} <= elapsed)
        begin
            dem_next = '0;
        end
        else if (diff[X_W-1])
        begin
            dem_next = DEMERIT_MAX;
        end
        else
        begin
            dem_next = diff[DEMERIT_W-1:0];
        end
    end

    assign ms_next = (dem_reg > demerit_limit_reg) ? (dem_reg - demerit_limit_reg) : '0;

    // The reciprocal estimate is at most one below the true quotient.
    assign x_val  = {1'b0, ms_reg} + X_W'(ROUND_UP_MS);
    assign prod   = PROD_W'(x_val) * PROD_W'(RECIP_1000);
    assign rem    = x_val - X_W'(qest_reg * X_W'(MS_PER_SEC));
    assign q_next = (rem >= X_W'(MS_PER_SEC)) ? (qest_reg + 1'b1) : qest_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hit_reg  <= valid_reg[raddr];
            addr_reg <= raddr;
            now_reg  <= in_data.now_ms;
        end
        if (cmd.write_back)
        begin
            dem_reg <= dem_next;
        end
        if (cmd.excess)
        begin
            ms_reg <= ms_next;
        end
        if (cmd.scale)
        begin
            qest_reg <= prod[RECIP_SHIFT + SECONDS_W - 1:RECIP_SHIFT];
        end
        if (cmd.clear)
        begin
            result_reg <= '0;
        end
        else if (cmd.fix)
        begin
            result_reg.wait_ms      <= ms_reg;
            result_reg.wait_seconds <= q_next;
            result_reg.limited      <= (ms_reg != '0);
        end
    end

    assign out_data = result_reg;

    a_flag_matches_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fix |=> (result_reg.limited == (result_reg.wait_ms != '0))
                    && ((result_reg.wait_seconds != '0) == result_reg.limited))
        else $error("limited flag disagrees with the wait fields");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (result_reg == '0))
        else $error("exempt request left a nonzero result");

endmodule

// ----- design/per_client_flood_limiter.sv -----
// ----------------------------------------------------------------------------
// per_client_flood_limiter: per-client leaky-bucket message policer
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// A request on in_data names a client slot, the current time in ms and a
// bypass bit; it is taken when in_valid is high and in_stall is low. Each
// request yields exactly one result on out_data, offered with out_valid and
// taken when out_stall is low.
// The block works on one request at a time. A limited request reads the
// client entry from the table RAM, updates it, finds the excess over the
// demerit limit and converts it to seconds, through the states CALC,
// EXCESS, SCALE and FIX before out_valid rises. An exempt request, or one
// while limiting is disabled, answers in the cycle after acceptance with
// an all-zero result. in_stall is low again the cycle after the result is
// taken, so no request is taken while another is in progress.
// While the receiver stalls, the result holds and no request is taken.
// Reset restores the interval to 2000 ms and the limit to 5000 and marks
// every client entry empty at once; no clearing pass is needed.
// Configuration writes on cfg_we, cfg_index and cfg_data take effect at
// the next clock edge and belong in idle periods.
// ----------------------------------------------------------------------------
module per_client_flood_limiter #(
    parameter int CLIENT_SLOTS = pcfl_pkg::CLIENT_SLOTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pcfl_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pcfl_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [pcfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcfl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pcfl_pkg::*;

    cmd_t    cmd;
    status_t status;

    pcfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pcfl_datapath #(
        .CLIENT_SLOTS(CLIENT_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
